### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BPFA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BPFA_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BPFA_ASSERT(lbl, clk, rstn, prop, msg)
`define BPFA_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### rtl/bpfa_pkg.sv
package bpfa_pkg;

	localparam int ADDR_W      = 28;
	localparam int FRAME_SHIFT = 12;
	localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
	localparam int LIMIT_W     = 17;
	localparam int ADDR_FRAMES = 65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	localparam int APB_DW  = 32;
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_FRAME_LIMIT = 1'b0;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 32;
	localparam int IN_USE_BIT = ADDR_W;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_TEST  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

endpackage

### rtl/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator: one used bit per 4 KiB frame, kept in a single-port-read,
// single-port-write synchronous RAM of WORD_BITS-bit words. After reset the block sweeps
// the RAM to zero, one word per cycle, and holds s_tready low meanwhile; frame_limit can
// be written during the sweep. Mark, free and test pass from acceptance to result through
// range check and reciprocal multiply, word/bit index, RAM read and read-modify-write; an
// address beyond the limit answers from the range check. Allocate streams the bitmap
// through the RAM read port at one word per cycle from word 0 and stops at the first word
// with a clear bit, then picks the lowest clear bit of that word. With nothing free it
// answers when the scan reaches the limit with every word below it full, or after the
// pick when the only clear bits lie past the limit; at a zero limit it reads no word. A
// stalled m_tready adds its stall. One command is in flight at a time; the result register
// lets the next command be accepted the cycle after a result is loaded, even while that
// result waits.
module bitmap_page_frame_allocator_unit #(
	parameter int MAX_FRAMES = 65536,
	parameter int WORD_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpfa_pkg::PADDR_W-1:0]   paddr,
	input  logic [bpfa_pkg::APB_DW-1:0]    pwdata,
	output logic [bpfa_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bpfa_pkg::S_TDATA_W-1:0] s_tdata,  // page_address[27:0], zero pad
	input  logic [1:0]                     s_tuser,  // cmd[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bpfa_pkg::M_TDATA_W-1:0] m_tdata,  // result_address[27:0], in_use, zero pad
	output logic [1:0]                     m_tuser   // status[1:0]
);
	import bpfa_pkg::*;

	localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int LIM_CAP   = (MAX_FRAMES < ADDR_FRAMES) ? MAX_FRAMES : ADDR_FRAMES;
	localparam int BASE_W    = LIMIT_W + 1;
	// frame / WORD_BITS as (frame * DIV_M) >> DIV_S, exact for all FRAME_W-bit frames
	localparam int DIV_S     = FRAME_W + BIT_W;
	localparam int DIV_M     = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
	localparam int DIV_M_W   = FRAME_W + 2;
	localparam int PROD_W    = FRAME_W + DIV_M_W;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_FIX,
		S_DIV,
		S_REM,
		S_RD,
		S_MOD
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	addr_t                addr_q;
	logic [LIMIT_W-1:0]   frame_limit_q;
	logic [WADDR_W-1:0]   clr_q;
	logic [WADDR_W-1:0]   scan_w_q;
	logic [BASE_W-1:0]    scan_base_q;
	logic                 rd_v_s1;
	logic [WADDR_W-1:0]   rd_w_s1;
	logic [BASE_W-1:0]    rd_base_s1;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] iso_q;
	logic [BASE_W-1:0]    base_q;
	logic [PROD_W-1:0]    prod_s1;
	logic [WADDR_W-1:0]   widx_q;
	logic [BIT_W-1:0]     bidx_q;
	logic                 m_tvalid_q;
	addr_t                m_addr_q;
	logic                 m_in_use_q;
	status_t              m_status_q;

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] mem_rd_s1;
	logic                 mem_we;
	logic [WADDR_W-1:0]   mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic [WADDR_W-1:0]   mem_ra;

	logic [LIMIT_W-1:0]   lim_eff;
	logic [FRAME_W-1:0]   frame;
	logic                 in_range;
	logic                 s_acc;
	logic                 out_free;
	logic                 res_load;
	logic                 scan_issue;
	logic                 rd_full;
	logic [WORD_BITS-1:0] iso;
	logic [BIT_W-1:0]     pick_idx;
	logic [BASE_W-1:0]    pick_frame;
	logic                 pick_ok;
	logic [FRAME_W-1:0]   quot;
	logic [FRAME_W-1:0]   rem;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 cur_bit;
	logic                 cfg_wr;
	logic                 cfg_hit;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[PADDR_W-1:2] == REG_FRAME_LIMIT);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? APB_DW'(frame_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			frame_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// bitmap RAM
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		mem_rd_s1 <= map_mem[mem_ra];
	end

	assign lim_eff  = (frame_limit_q > LIMIT_W'(LIM_CAP)) ? LIMIT_W'(LIM_CAP) : frame_limit_q;
	assign frame    = addr_q[ADDR_W-1:FRAME_SHIFT];
	assign in_range = ({1'b0, frame} < lim_eff);
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign scan_issue = (scan_base_q < BASE_W'(lim_eff));
	assign rd_full    = &mem_rd_s1;

	// lowest clear bit of the chosen word, as a one-hot mask
	assign iso = ~word_q & (word_q + WORD_BITS'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso_q[i]) begin
				pick_idx = pick_idx | BIT_W'(i);
			end
		end
	end

	assign pick_frame = base_q + BASE_W'(pick_idx);
	assign pick_ok    = (pick_frame < BASE_W'(lim_eff));

	assign quot     = FRAME_W'(prod_s1 >> DIV_S);
	assign rem      = frame - FRAME_W'(quot * FRAME_W'(WORD_BITS));
	assign bit_mask = WORD_BITS'(1) << bidx_q;
	assign cur_bit  = mem_rd_s1[bidx_q];

	// a finishing state loads the result register
	always_comb begin
		case (state_q)
			S_SCAN:  res_load = out_free && !rd_v_s1 && !scan_issue;
			S_FIX:   res_load = out_free;
			S_DIV:   res_load = out_free && !in_range;
			S_MOD:   res_load = out_free;
			default: res_load = 1'b0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = widx_q;
		mem_wd = '0;
		mem_ra = widx_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_SCAN: begin
				mem_ra = scan_w_q;
			end
			S_FIX: begin
				mem_we = out_free && pick_ok;
				mem_wd = word_q | iso_q;
			end
			S_MOD: begin
				mem_we = out_free && (cmd_q == CMD_MARK || cmd_q == CMD_FREE);
				mem_wd = (cmd_q == CMD_MARK) ? (mem_rd_s1 | bit_mask)
				                              : (mem_rd_s1 & ~bit_mask);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cmd_q       <= CMD_ALLOC;
			addr_q      <= '0;
			clr_q       <= '0;
			scan_w_q    <= '0;
			scan_base_q <= '0;
			rd_v_s1     <= 1'b0;
			rd_w_s1     <= '0;
			rd_base_s1  <= '0;
			word_q      <= '0;
			iso_q       <= '0;
			base_q      <= '0;
			prod_s1     <= '0;
			widx_q      <= '0;
			bidx_q      <= '0;
			m_tvalid_q  <= 1'b0;
			m_addr_q    <= '0;
			m_in_use_q  <= 1'b0;
			m_status_q  <= ST_OK;
		end else begin
			m_tvalid_q <= res_load || (m_tvalid_q && !m_tready);
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + WADDR_W'(1);
					if (clr_q == WADDR_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						cmd_q       <= cmd_t'(s_tuser);
						addr_q      <= s_tdata[ADDR_W-1:0];
						scan_w_q    <= '0;
						scan_base_q <= '0;
						rd_v_s1     <= 1'b0;
						state_q     <= (cmd_t'(s_tuser) == CMD_ALLOC) ? S_SCAN : S_DIV;
					end
				end
				S_SCAN: begin
					// one read issued per cycle; data of the previous read checked here
					if (rd_v_s1 && !rd_full) begin
						word_q  <= mem_rd_s1;
						base_q  <= rd_base_s1;
						widx_q  <= rd_w_s1;
						rd_v_s1 <= 1'b0;
						state_q <= S_PICK;
					end else if (!rd_v_s1 && !scan_issue) begin
						if (out_free) begin
							m_addr_q   <= '0;
							m_in_use_q <= 1'b0;
							m_status_q <= ST_NOFREE;
							state_q    <= S_IDLE;
						end
					end else begin
						rd_v_s1    <= scan_issue;
						rd_w_s1    <= scan_w_q;
						rd_base_s1 <= scan_base_q;
						if (scan_issue) begin
							scan_w_q    <= scan_w_q + WADDR_W'(1);
							scan_base_q <= scan_base_q + BASE_W'(WORD_BITS);
						end
					end
				end
				S_PICK: begin
					iso_q   <= iso;
					state_q <= S_FIX;
				end
				S_FIX: begin
					// a clear bit at or past the limit in the first open word means none free
					if (out_free) begin
						m_in_use_q <= 1'b0;
						if (pick_ok) begin
							m_addr_q   <= {pick_frame[FRAME_W-1:0], {FRAME_SHIFT{1'b0}}};
							m_status_q <= ST_OK;
						end else begin
							m_addr_q   <= '0;
							m_status_q <= ST_NOFREE;
						end
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (!in_range) begin
						if (out_free) begin
							m_addr_q   <= addr_q;
							m_in_use_q <= 1'b0;
							m_status_q <= ST_RANGE;
							state_q    <= S_IDLE;
						end
					end else begin
						prod_s1 <= PROD_W'(frame) * PROD_W'(DIV_M);
						state_q <= S_REM;
					end
				end
				S_REM: begin
					widx_q  <= WADDR_W'(quot);
					bidx_q  <= BIT_W'(rem);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (out_free) begin
						m_addr_q   <= addr_q;
						m_in_use_q <= cur_bit;
						m_status_q <= ST_OK;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({m_in_use_q, m_addr_q});
	assign m_tuser  = m_status_q;

`include "assert_macros.svh"

	`BPFA_ASSERT(a_we_states, clk, arst_n, mem_we |-> (state_q == S_CLR || state_q == S_FIX || state_q == S_MOD), "bitmap written outside a write state")
	`BPFA_ASSERT(a_res_src, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == S_SCAN || state_q == S_FIX || state_q == S_DIV || state_q == S_MOD), "result raised without a finishing command")
	`BPFA_ASSERT(a_fail_clear, clk, arst_n, (m_tvalid && m_tuser != ST_OK) |-> !m_tdata[IN_USE_BIT], "failed command reports frame in use")
	`BPFA_NEVER(a_clr_quiet, clk, arst_n, state_q == S_CLR && m_tvalid, "result shown during bitmap clear")

endmodule
